[sv/nmea_gga_sentence_parser_unit_macros.svh]
// assertion macros shared by the parser modules
`ifndef NMEA_GGA_SENTENCE_PARSER_UNIT_MACROS_SVH
`define NMEA_GGA_SENTENCE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NGGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NGGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ngga_pkg.sv]
// shared constants, types and helpers of the gga sentence parser
package ngga_pkg;

  localparam int unsigned MAX_LINE_DEF = 127;
  localparam int unsigned FRAC_DIGITS  = 5;

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam int unsigned FRAC_SCALE = pow10(FRAC_DIGITS);
  localparam int unsigned FRAC_W     = $clog2(FRAC_SCALE);
  localparam int unsigned FCNT_W     = 3;

  // minutes/60 in 1e-7 degrees reduces to n * ScaleNum / ScaleDen
  localparam int unsigned FRAC_GAP   = pow10(7 - FRAC_DIGITS);
  localparam int unsigned SCALE_NUM  = (FRAC_GAP == 1) ? 1 : (FRAC_GAP == 10) ? 1 : FRAC_GAP / 20;
  localparam int unsigned SCALE_DEN  = (FRAC_GAP == 1) ? 60 : (FRAC_GAP == 10) ? 6 : 3;
  localparam int unsigned MINU_W     = $clog2(60 * FRAC_SCALE);
  localparam int unsigned PROD_W     = $clog2(60 * FRAC_SCALE * SCALE_NUM + 1);
  localparam int unsigned RECIP_SH   = 30;
  localparam longint unsigned RECIP_VAL = (longint'(1) << RECIP_SH) / SCALE_DEN;
  localparam int unsigned QUO_W      = 24;

  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV100_SH  = 19;

  localparam int unsigned COORD_CAP  = 32767;
  localparam int unsigned UTC_CAP    = 999999;
  localparam int unsigned DEG_E7     = 10000000;
  localparam int unsigned LAT_LIMIT  = 900000000;
  localparam int unsigned COORD_STAGES = 7;

  typedef enum logic [1:0] {
    ST_BAD_SUM  = 2'd0,
    ST_NOT_GGA  = 2'd1,
    ST_NO_FIX   = 2'd2,
    ST_ACCEPTED = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [14:0]         lat_ip;
    logic [FRAC_W-1:0]   lat_fp;
    logic [14:0]         lon_ip;
    logic [FRAC_W-1:0]   lon_fp;
    logic [7:0]          ns;
    logic [7:0]          ew;
    logic [7:0]          fix;
    logic [7:0]          sat;
    logic [19:0]         utc_int;
    logic [6:0]          utc_frac;
  } line_sum_t;

  // sentence heads "$GPGGA" and "$GNGGA"
  function automatic logic [7:0] gga_char(input logic [2:0] idx, input logic alt);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "$";
      3'd1:    c = "G";
      3'd2:    c = alt ? "N" : "P";
      3'd3:    c = "G";
      3'd4:    c = "G";
      3'd5:    c = "A";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] h;
    if (b >= "0" && b <= "9") begin
      h = {1'b0, b[3:0]};
    end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
      h = {1'b0, b[3:0] + 4'd9};
    end else begin
      h = 5'h10;
    end
    return h;
  endfunction

endpackage

[sv/ngga_front.sv]
// byte scanner: checksum, head match, field parsing, one summary per line
module ngga_front import ngga_pkg::*; #(
  parameter int unsigned MaxLine = MAX_LINE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] line_byte_i,
  input  logic       line_end_i,
  input  logic       q_full_i,
  output logic       push_o,
  output line_sum_t  sum_o
);

  localparam int unsigned PosW = $clog2(MaxLine + 1);

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_HEX    = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [7:0]        min_sat_q;
  logic [7:0]        xor_q, xor_d, rsum_q, rsum_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [1:0]        phase_q, phase_d;
  logic [3:0]        fld_q, fld_d;
  logic [1:0]        tm_q, tm_d;
  logic [14:0]       lat_ip_q, lat_ip_d, lon_ip_q, lon_ip_d;
  logic [FRAC_W-1:0] lat_fp_q, lat_fp_d, lon_fp_q, lon_fp_d;
  logic [7:0]        fix_q, fix_d, sat_q, sat_d;
  logic [19:0]       utc_q, utc_d;
  logic [6:0]        utcf_q, utcf_d;
  logic [7:0]        ns_q, ns_d, ew_q, ew_d;
  logic              nonempty_q, nonempty_d, point_q, point_d, stop_q, stop_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic              ended_q, ended_d;

  logic              take;
  logic [7:0]        b;
  logic [3:0]        dig;
  logic              is_dig;
  logic [4:0]        hv;
  logic [23:0]       utc_v;
  logic [18:0]       crd_v;
  logic [14:0]       crd_ip;
  logic [FRAC_W-1:0] crd_fp;
  logic [FRAC_W+3:0] crd_fv;
  logic [15:0]       cnt_v;
  status_e           st;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = take && line_end_i;
  assign b          = line_byte_i;
  assign dig        = b[3:0];
  assign is_dig     = (b >= "0") && (b <= "9");
  assign hv         = hex_val(b);

  always_comb begin
    xor_d = xor_q; rsum_d = rsum_q; pos_d = pos_q; phase_d = phase_q;
    fld_d = fld_q; tm_d = tm_q; lat_ip_d = lat_ip_q; lat_fp_d = lat_fp_q;
    lon_ip_d = lon_ip_q; lon_fp_d = lon_fp_q; fix_d = fix_q; sat_d = sat_q;
    utc_d = utc_q; utcf_d = utcf_q; ns_d = ns_q; ew_d = ew_q;
    nonempty_d = nonempty_q; point_d = point_q; stop_d = stop_q;
    fcnt_d = fcnt_q; ended_d = ended_q;
    crd_ip = (fld_q == 4'd5) ? lon_ip_q : lat_ip_q;
    crd_fp = (fld_q == 4'd5) ? lon_fp_q : lat_fp_q;
    utc_v  = 24'(utc_q) * 24'd10 + 24'(dig);
    crd_v  = 19'(crd_ip) * 19'd10 + 19'(dig);
    crd_fv = (FRAC_W + 4)'(crd_fp) * (FRAC_W + 4)'(10) + (FRAC_W + 4)'(dig);
    cnt_v  = 16'((fld_q == 4'd8) ? sat_q : fix_q) * 16'd10 + 16'(dig);

    if (take && !ended_q && (pos_q < PosW'(MaxLine))) begin
      if (b == 8'h00) begin
        ended_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_BEFORE: begin
            if (b == "*") begin
              phase_d = PH_HEX;
            end else if (!((pos_q == '0) && (b == "$"))) begin
              xor_d = xor_q ^ b;
            end
          end
          PH_HEX: begin
            if (!hv[4]) begin
              rsum_d = {rsum_q[3:0], hv[3:0]};
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase

        if (pos_q < PosW'(6)) begin
          if (b != gga_char(pos_q[2:0], 1'b0)) tm_d[0] = 1'b0;
          if (b != gga_char(pos_q[2:0], 1'b1)) tm_d[1] = 1'b0;
        end

        if (b == ",") begin
          if (fld_q < 4'd15) fld_d = fld_q + 4'd1;
          nonempty_d = 1'b0;
          point_d    = 1'b0;
          stop_d     = 1'b0;
          fcnt_d     = '0;
        end else begin
          unique case (fld_q)
            4'd2: begin
              if (!stop_q) begin
                if (is_dig) begin
                  if (!point_q) begin
                    utc_d = (utc_v > 24'(UTC_CAP)) ? 20'(UTC_CAP) : utc_v[19:0];
                  end else if (fcnt_q == FCNT_W'(0)) begin
                    utcf_d = 7'(dig) * 7'd10;
                    fcnt_d = FCNT_W'(1);
                  end else if (fcnt_q == FCNT_W'(1)) begin
                    utcf_d = utcf_q + 7'(dig);
                    fcnt_d = FCNT_W'(2);
                  end
                end else if (b == "." && !point_q) begin
                  point_d = 1'b1;
                end else begin
                  stop_d = 1'b1;
                end
              end
            end
            4'd3, 4'd5: begin
              if (!stop_q) begin
                if (is_dig) begin
                  if (!point_q) begin
                    if (fld_q == 4'd5) begin
                      lon_ip_d = (crd_v > 19'(COORD_CAP)) ? 15'(COORD_CAP) : crd_v[14:0];
                    end else begin
                      lat_ip_d = (crd_v > 19'(COORD_CAP)) ? 15'(COORD_CAP) : crd_v[14:0];
                    end
                  end else if (fcnt_q < FCNT_W'(FRAC_DIGITS)) begin
                    if (fld_q == 4'd5) begin
                      lon_fp_d = crd_fv[FRAC_W-1:0];
                    end else begin
                      lat_fp_d = crd_fv[FRAC_W-1:0];
                    end
                    fcnt_d = fcnt_q + FCNT_W'(1);
                  end
                end else if (b == "." && !point_q) begin
                  point_d = 1'b1;
                end else begin
                  stop_d = 1'b1;
                end
              end
            end
            4'd4: if (!nonempty_q) ns_d = b;
            4'd6: if (!nonempty_q) ew_d = b;
            4'd7, 4'd8: begin
              if (!stop_q) begin
                if (is_dig) begin
                  if (fld_q == 4'd8) sat_d = cnt_v[7:0];
                  else fix_d = cnt_v[7:0];
                end else begin
                  stop_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
          nonempty_d = 1'b1;
        end
        pos_d = pos_q + PosW'(1);
      end
    end

    priority if ((phase_d == PH_BEFORE) || (xor_d != rsum_d)) begin
      st = ST_BAD_SUM;
    end else if ((pos_d < PosW'(6)) || (tm_d == 2'b00)) begin
      st = ST_NOT_GGA;
    end else if ((fix_d != 8'd0) && (sat_d >= min_sat_q)) begin
      st = ST_ACCEPTED;
    end else begin
      st = ST_NO_FIX;
    end

    sum_o.status   = st;
    sum_o.lat_ip   = lat_ip_d;
    sum_o.lat_fp   = lat_fp_d;
    sum_o.lon_ip   = lon_ip_d;
    sum_o.lon_fp   = lon_fp_d;
    sum_o.ns       = ns_d;
    sum_o.ew       = ew_d;
    sum_o.fix      = fix_d;
    sum_o.sat      = sat_d;
    sum_o.utc_int  = utc_d;
    sum_o.utc_frac = utcf_d;

    // a finished line leaves fresh state for the next one
    if (push_o) begin
      xor_d = '0; rsum_d = '0; pos_d = '0; phase_d = PH_BEFORE;
      fld_d = 4'd1; tm_d = 2'b11; lat_ip_d = '0; lat_fp_d = '0;
      lon_ip_d = '0; lon_fp_d = '0; fix_d = '0; sat_d = '0;
      utc_d = '0; utcf_d = '0; ns_d = "N"; ew_d = "E";
      nonempty_d = 1'b0; point_d = 1'b0; stop_d = 1'b0;
      fcnt_d = '0; ended_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sat_q <= 8'd4;
      xor_q <= '0; rsum_q <= '0; pos_q <= '0; phase_q <= PH_BEFORE;
      fld_q <= 4'd1; tm_q <= 2'b11; lat_ip_q <= '0; lat_fp_q <= '0;
      lon_ip_q <= '0; lon_fp_q <= '0; fix_q <= '0; sat_q <= '0;
      utc_q <= '0; utcf_q <= '0; ns_q <= "N"; ew_q <= "E";
      nonempty_q <= 1'b0; point_q <= 1'b0; stop_q <= 1'b0;
      fcnt_q <= '0; ended_q <= 1'b0;
    end else begin
      if (cfg_we_i) min_sat_q <= cfg_wdata_i;
      xor_q <= xor_d; rsum_q <= rsum_d; pos_q <= pos_d; phase_q <= phase_d;
      fld_q <= fld_d; tm_q <= tm_d; lat_ip_q <= lat_ip_d; lat_fp_q <= lat_fp_d;
      lon_ip_q <= lon_ip_d; lon_fp_q <= lon_fp_d; fix_q <= fix_d; sat_q <= sat_d;
      utc_q <= utc_d; utcf_q <= utcf_d; ns_q <= ns_d; ew_q <= ew_d;
      nonempty_q <= nonempty_d; point_q <= point_d; stop_q <= stop_d;
      fcnt_q <= fcnt_d; ended_q <= ended_d;
    end
  end

endmodule

[sv/ngga_queue.sv]
// two-entry queue of line summaries between scanner and converter
module ngga_queue import ngga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_sum_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output line_sum_t data_o
);

  `include "nmea_gga_sentence_parser_unit_macros.svh"

  line_sum_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `NGGA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= 2'd2, "queue count out of range")
  `NGGA_ASSERT_NEXT(a_count_grow, push_i && !pop_i, count_q == $past(count_q) + 2'd1,
                    "queue count missed a push")
  `NGGA_ASSERT_NOW(a_no_overrun, push_i && !pop_i, !full_o, "push into full queue")

endmodule

[sv/ngga_coord.sv]
// pipelined DDMM.fraction to 1e-7 degree magnitude, zero when out of range
module ngga_coord import ngga_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [14:0]       ip_i,
  input  logic [FRAC_W-1:0] fp_i,
  output logic [30:0]       mag_o
);

  logic [29:0]        prod1;
  logic [8:0]         deg1_q;
  logic [14:0]        ip1_q;
  logic [FRAC_W-1:0]  fp1_q, fp2_q;
  logic [14:0]        mm_full;
  logic [6:0]         mm2_q;
  logic [8:0]         deg2_q;
  logic               zero2_q, zero3_q, zero4_q, zero5_q, zero6_q;
  logic [MINU_W-1:0]  n3_q;
  logic [30:0]        dege3_q, dege4_q, dege5_q, dege6_q;
  logic [PROD_W-1:0]  x4_q, x5_q;
  logic [PROD_W+RECIP_SH-1:0] qprod;
  logic [QUO_W-1:0]   q5_q, q6_q;
  logic [PROD_W-1:0]  rem;
  logic [QUO_W-1:0]   qfix;

  assign prod1   = 30'(ip_i) * 30'(DIV100_MUL);
  assign mm_full = ip1_q - 15'(deg1_q) * 15'd100;
  assign qprod   = (PROD_W + RECIP_SH)'(x4_q) * (PROD_W + RECIP_SH)'(RECIP_VAL);
  assign rem     = x5_q - PROD_W'(q5_q) * PROD_W'(SCALE_DEN);

  // reciprocal quotient runs at most two short
  always_comb begin
    priority if (rem >= PROD_W'(2 * SCALE_DEN)) qfix = q5_q + QUO_W'(2);
    else if (rem >= PROD_W'(SCALE_DEN)) qfix = q5_q + QUO_W'(1);
    else qfix = q5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      deg1_q  <= prod1[DIV100_SH +: 9];
      ip1_q   <= ip_i;
      fp1_q   <= fp_i;
      mm2_q   <= mm_full[6:0];
      deg2_q  <= deg1_q;
      fp2_q   <= fp1_q;
      zero2_q <= (ip1_q > 15'd18000) || ((ip1_q == 15'd18000) && (fp1_q != '0)) ||
                 (mm_full >= 15'd60);
      n3_q    <= MINU_W'(mm2_q) * MINU_W'(FRAC_SCALE) + MINU_W'(fp2_q);
      dege3_q <= 31'(deg2_q) * 31'(DEG_E7);
      zero3_q <= zero2_q;
      x4_q    <= PROD_W'(n3_q) * PROD_W'(SCALE_NUM);
      dege4_q <= dege3_q;
      zero4_q <= zero3_q;
      q5_q    <= qprod[RECIP_SH +: QUO_W];
      x5_q    <= x4_q;
      dege5_q <= dege4_q;
      zero5_q <= zero4_q;
      q6_q    <= qfix;
      dege6_q <= dege5_q;
      zero6_q <= zero5_q;
      mag_o   <= zero6_q ? 31'd0 : dege6_q + 31'(q6_q);
    end
  end

endmodule

[sv/ngga_back.sv]
// converter: coordinate pipelines, sign and output register
module ngga_back import ngga_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  line_sum_t          q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic [7:0]         north_south_o,
  output logic [7:0]         east_west_o,
  output logic [7:0]         fix_quality_o,
  output logic [7:0]         satellites_o,
  output logic [19:0]        utc_hhmmss_o,
  output logic [6:0]         utc_hundredths_o
);

  `include "nmea_gga_sentence_parser_unit_macros.svh"

  logic        adv;
  logic [30:0] lat_mag, lon_mag, lat_cap;
  line_sum_t   sum_q [COORD_STAGES];
  logic        vld_q [COORD_STAGES];
  line_sum_t   last;
  logic        ok;

  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && q_valid_i;
  assign last  = sum_q[COORD_STAGES-1];
  assign ok    = (last.status == ST_ACCEPTED);
  assign lat_cap = (lat_mag > 31'(LAT_LIMIT)) ? 31'(LAT_LIMIT) : lat_mag;

  ngga_coord u_lat (
    .clk_i (clk_i),
    .adv_i (adv),
    .ip_i  (q_data_i.lat_ip),
    .fp_i  (q_data_i.lat_fp),
    .mag_o (lat_mag)
  );

  ngga_coord u_lon (
    .clk_i (clk_i),
    .adv_i (adv),
    .ip_i  (q_data_i.lon_ip),
    .fp_i  (q_data_i.lon_fp),
    .mag_o (lon_mag)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q[0] <= q_data_i;
      for (int i = 1; i < COORD_STAGES; i++) begin
        sum_q[i] <= sum_q[i-1];
      end
      status_o         <= last.status;
      latitude_e7_o    <= !ok ? 31'sd0 : (last.ns == "S") ? -$signed(lat_cap) : $signed(lat_cap);
      longitude_e7_o   <= !ok ? 32'sd0 :
                          (last.ew == "W") ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
      north_south_o    <= ok ? last.ns : 8'd0;
      east_west_o      <= ok ? last.ew : 8'd0;
      fix_quality_o    <= ok ? last.fix : 8'd0;
      satellites_o     <= ok ? last.sat : 8'd0;
      utc_hhmmss_o     <= ok ? last.utc_int : 20'd0;
      utc_hundredths_o <= ok ? last.utc_frac : 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COORD_STAGES; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_o <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int i = 1; i < COORD_STAGES; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_o <= vld_q[COORD_STAGES-1];
    end
  end

  `NGGA_ASSERT_NOW(a_reject_zero, out_valid_o && (status_o != ST_ACCEPTED),
                   (latitude_e7_o == 31'sd0) && (longitude_e7_o == 32'sd0) &&
                   (fix_quality_o == 8'd0), "rejected line carries nonzero fields")
  `NGGA_ASSERT_NOW(a_lat_range, out_valid_o,
                   (latitude_e7_o <= 31'sd900000000) && (latitude_e7_o >= -31'sd900000000),
                   "latitude beyond ninety degrees")

endmodule

[sv/nmea_gga_sentence_parser_unit.sv]
// GGA sentence parser: takes one byte per clock while in_ready_o is high; the
// beat carrying line_end yields one result beat. A scanner checks the checksum
// and sentence head and parses the fields as bytes arrive; at line end it
// pushes a summary into a two-entry queue. The converter turns coordinates into
// 1e-7 degrees through a seven-stage constant-multiply pipeline and an output
// register. Input throughput is one byte per clock, set by the scanner, and
// holds as long as results are taken; a stalled output backs up the converter
// and then the queue, after which the scanner holds in_ready_o low. No
// clearing pass after reset.
module nmea_gga_sentence_parser_unit import ngga_pkg::*; #(
  parameter int unsigned MaxLine = MAX_LINE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         line_byte_i,
  input  logic               line_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic [7:0]         north_south_o,
  output logic [7:0]         east_west_o,
  output logic [7:0]         fix_quality_o,
  output logic [7:0]         satellites_o,
  output logic [19:0]        utc_hhmmss_o,
  output logic [6:0]         utc_hundredths_o
);

  logic      push, full, q_valid, pop;
  line_sum_t sum_in, sum_out;

  ngga_front #(.MaxLine(MaxLine)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .line_byte_i (line_byte_i),
    .line_end_i  (line_end_i),
    .q_full_i    (full),
    .push_o      (push),
    .sum_o       (sum_in)
  );

  ngga_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (sum_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (sum_out)
  );

  ngga_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (sum_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .latitude_e7_o    (latitude_e7_o),
    .longitude_e7_o   (longitude_e7_o),
    .north_south_o    (north_south_o),
    .east_west_o      (east_west_o),
    .fix_quality_o    (fix_quality_o),
    .satellites_o     (satellites_o),
    .utc_hhmmss_o     (utc_hhmmss_o),
    .utc_hundredths_o (utc_hundredths_o)
  );

endmodule

[tb/nmea_gga_sentence_parser_unit_tb.sv]
// self-checking testbench for the gga sentence parser: directed sentences, then random lines
module nmea_gga_sentence_parser_unit_tb;
  import ngga_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineCap   = 127;
  localparam int unsigned FracKeep  = 5;
  localparam int unsigned RandBytes = 700;
  localparam int unsigned MinLines  = 60;
  localparam int unsigned DrainWait = 20;
  localparam longint unsigned CycleLimit = 600000;

  // checksum handling for a line
  localparam int CK_GOOD  = 0;
  localparam int CK_LOWER = 1;
  localparam int CK_BAD   = 2;
  localparam int CK_NONE  = 3;
  localparam int CK_PAD   = 4;
  localparam int NO_KNOWN = -1;

  typedef bit [7:0] u8_t;

  typedef struct {
    status_e            status;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [7:0]         ns;
    logic [7:0]         ew;
    logic [7:0]         fix;
    logic [7:0]         sat;
    logic [19:0]        utc;
    logic [6:0]         hund;
    int                 known;
  } gga_fix_t;

  typedef struct {
    string body;
    int    ck;
    int    known;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [7:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         line_byte_i = '0;
  logic               line_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [30:0] latitude_e7_o;
  logic signed [31:0] longitude_e7_o;
  logic [7:0]         north_south_o;
  logic [7:0]         east_west_o;
  logic [7:0]         fix_quality_o;
  logic [7:0]         satellites_o;
  logic [19:0]        utc_hhmmss_o;
  logic [6:0]         utc_hundredths_o;

  nmea_gga_sentence_parser_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .line_byte_i, .line_end_i,
    .out_valid_o, .out_ready_i, .status_o, .latitude_e7_o, .longitude_e7_o,
    .north_south_o, .east_west_o, .fix_quality_o, .satellites_o,
    .utc_hhmmss_o, .utc_hundredths_o
  );

  always #4 clk_i = ~clk_i;

  // sentence state mirrored from the block
  bit [7:0]  min_sats;
  bit [7:0]  sum_calc, sum_given;
  int        pos, scan_ph, fld, frac_cnt;
  bit [1:0]  head_ok;
  bit        f_nonempty, f_point, f_stop, text_done;
  longint    lat_ip, lat_fp, lon_ip, lon_fp, utc_ip, utc_fp;
  bit [7:0]  fix_acc, sat_acc, ns_byte, ew_byte;

  gga_fix_t  fix_q[$];
  int        in_idle_pct, out_stall_pct, known_next;
  bit        hold_out;
  int        errors, n_bytes, n_lines, n_checked, n_accepted;
  longint unsigned cycles;

  task automatic clear_sentence();
    sum_calc = 0; sum_given = 0; pos = 0; scan_ph = 0; fld = 1; frac_cnt = 0;
    head_ok = 2'b11; f_nonempty = 0; f_point = 0; f_stop = 0; text_done = 0;
    lat_ip = 0; lat_fp = 0; lon_ip = 0; lon_fp = 0; utc_ip = 0; utc_fp = 0;
    fix_acc = 0; sat_acc = 0; ns_byte = "N"; ew_byte = "E";
  endtask

  task automatic take_number(input u8_t b, ref longint ip, ref longint fp,
                             input longint cap, input bit is_utc);
    if (f_stop) return;
    if (b >= "0" && b <= "9") begin
      if (!f_point) begin
        ip = ip * 10 + (b - "0");
        if (ip > cap) ip = cap;
      end else if (is_utc) begin
        if (frac_cnt == 0) begin
          fp = (b - "0") * 10; frac_cnt = 1;
        end else if (frac_cnt == 1) begin
          fp += b - "0"; frac_cnt = 2;
        end
      end else if (frac_cnt < FracKeep) begin
        fp = fp * 10 + (b - "0"); frac_cnt++;
      end
    end else if (b == "." && !f_point) begin
      f_point = 1;
    end else begin
      f_stop = 1;
    end
  endtask

  task automatic take_count(input u8_t b, ref bit [7:0] v);
    if (f_stop) return;
    if (b >= "0" && b <= "9") v = v * 8'd10 + (b - "0");
    else f_stop = 1;
  endtask

  function automatic int hex_digit(input u8_t b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return 16;
  endfunction

  task automatic scan_byte(input u8_t b);
    u8_t gp[6];
    int  h;
    gp = '{"$", "G", "P", "G", "G", "A"};
    if (scan_ph == 0) begin
      if (b == "*") scan_ph = 1;
      else if (!(pos == 0 && b == "$")) sum_calc ^= b;
    end else if (scan_ph == 1) begin
      h = hex_digit(b);
      if (h < 16) sum_given = {sum_given[3:0], h[3:0]};
      else scan_ph = 2;
    end
    if (pos < 6) begin
      if (b != gp[pos]) head_ok[0] = 0;
      if (b != ((pos == 2) ? u8_t'("N") : gp[pos])) head_ok[1] = 0;
    end
    if (b == ",") begin
      if (fld < 15) fld++;
      f_nonempty = 0; f_point = 0; f_stop = 0; frac_cnt = 0;
      return;
    end
    case (fld)
      2: take_number(b, utc_ip, utc_fp, 999999, 1);
      3: take_number(b, lat_ip, lat_fp, 32767, 0);
      4: if (!f_nonempty) ns_byte = b;
      5: take_number(b, lon_ip, lon_fp, 32767, 0);
      6: if (!f_nonempty) ew_byte = b;
      7: take_count(b, fix_acc);
      8: take_count(b, sat_acc);
      default: ;
    endcase
    f_nonempty = 1;
  endtask

  function automatic longint degrees_e7(input longint ip, input longint fp);
    longint scale, mm;
    scale = 1;
    for (int i = 0; i < FracKeep; i++) scale *= 10;
    mm = ip % 100;
    if (ip > 18000 || (ip == 18000 && fp != 0) || mm >= 60) return 0;
    return (ip / 100) * 10000000 + ((mm * scale + fp) * 10000000) / (60 * scale);
  endfunction

  // returns 1 when this byte closes the line
  task automatic parse_beat(input u8_t b, input bit last, output bit done,
                            output gga_fix_t r);
    longint lat, lon;
    r = '{status: ST_BAD_SUM, default: '0};
    r.known = NO_KNOWN;
    done = last;
    if (!text_done && pos < LineCap) begin
      if (b == 0) text_done = 1;
      else begin
        scan_byte(b);
        pos++;
      end
    end
    if (!last) return;
    if (scan_ph == 0 || sum_calc != sum_given) r.status = ST_BAD_SUM;
    else if (pos < 6 || head_ok == 0) r.status = ST_NOT_GGA;
    else if (fix_acc > 0 && sat_acc >= min_sats) r.status = ST_ACCEPTED;
    else r.status = ST_NO_FIX;
    if (r.status == ST_ACCEPTED) begin
      lat = degrees_e7(lat_ip, lat_fp);
      lon = degrees_e7(lon_ip, lon_fp);
      if (lat > 900000000) lat = 900000000;
      if (ns_byte == "S") lat = -lat;
      if (ew_byte == "W") lon = -lon;
      r.lat = lat[30:0]; r.lon = lon[31:0];
      r.ns = ns_byte; r.ew = ew_byte; r.fix = fix_acc; r.sat = sat_acc;
      r.utc = utc_ip[19:0]; r.hund = utc_fp[6:0];
    end
    clear_sentence();
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on result %0d, %s: got %0d expected %0d", n_checked, what, got, want);
    errors++;
  endtask

  // both sides sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    bit       done;
    gga_fix_t r, w;
    if (rst_ni && in_valid_i && in_ready_o) begin
      parse_beat(line_byte_i, line_end_i, done, r);
      if (done) begin
        r.known = known_next;
        fix_q.push_back(r);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fix_q.size() == 0) begin
        report("result beat with no sentence pending", status_o, NO_KNOWN);
      end else begin
        w = fix_q.pop_front();
        if (w.known != NO_KNOWN && status_o != w.known) report("listed status", status_o, w.known);
        if (status_o != w.status) report("status", status_o, w.status);
        if (latitude_e7_o != w.lat) report("latitude", latitude_e7_o, w.lat);
        if (longitude_e7_o != w.lon) report("longitude", longitude_e7_o, w.lon);
        if (north_south_o != w.ns) report("n/s", north_south_o, w.ns);
        if (east_west_o != w.ew) report("e/w", east_west_o, w.ew);
        if (fix_quality_o != w.fix) report("fix", fix_quality_o, w.fix);
        if (satellites_o != w.sat) report("satellites", satellites_o, w.sat);
        if (utc_hhmmss_o != w.utc) report("utc", utc_hhmmss_o, w.utc);
        if (utc_hundredths_o != w.hund) report("hundredths", utc_hundredths_o, w.hund);
        if (status_o == ST_ACCEPTED) n_accepted++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_out && ($urandom_range(99) >= out_stall_pct);
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, fix_q.size());
      $display("** nmea_gga_sentence_parser_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input u8_t b, input bit last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_byte_i <= b;
    line_end_i  <= last;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    n_bytes++;
  endtask

  task automatic send_line(ref u8_t q[$], input int known);
    known_next = known;
    foreach (q[i]) send_beat(q[i], i == q.size() - 1);
    n_lines++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fix_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_min_sats(input int v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_sats = v[7:0];
  endtask

  task automatic push_text(ref u8_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  function automatic string rnd_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
    return s;
  endfunction

  // star and hex digits unless CK_NONE; CK_PAD first adds padding past the line cap
  task automatic close_line(ref u8_t q[$], input int ck);
    bit [7:0] x;
    x = 0;
    foreach (q[i]) if (!(i == 0 && q[i] == "$")) x ^= q[i];
    if (ck == CK_PAD) repeat (LineCap) q.push_back(",");
    case (ck)
      CK_GOOD, CK_PAD: push_text(q, $sformatf("*%02X", x));
      CK_LOWER:        push_text(q, $sformatf("*%02x", x));
      CK_BAD:          push_text(q, $sformatf("*%02X", x ^ 8'h5a));
      default:         ;
    endcase
  endtask

  task automatic random_line(ref u8_t q[$]);
    int r, ck;
    r = $urandom_range(99);
    if (r < 6) begin
      repeat ($urandom_range(1, 20)) q.push_back($urandom_range(0, 255));
      return;
    end
    r = $urandom_range(99);
    if (r < 45) push_text(q, "$GPGGA");
    else if (r < 90) push_text(q, "$GNGGA");
    else push_text(q, $sformatf("%sG%cGGA", ($urandom_range(1) ? "$" : ""),
                                $urandom_range(65, 90)));
    push_text(q, ",");
    if ($urandom_range(9) != 0) push_text(q, rnd_digits($urandom_range(9) ? 6 : 9));
    if ($urandom_range(1)) push_text(q, {".", rnd_digits($urandom_range(3))});
    push_text(q, ",");
    if ($urandom_range(9) != 0) begin
      push_text(q, $sformatf("%02d%02d.%s", $urandom_range(95),
                             $urandom_range($urandom_range(9) ? 59 : 99),
                             rnd_digits($urandom_range(8))));
    end
    case ($urandom_range(4))
      0: push_text(q, ",N,");
      1: push_text(q, ",S,");
      2: push_text(q, ",,");
      3: push_text(q, ",SOUTH,");
      default: push_text(q, $sformatf(",%c,", $urandom_range(65, 90)));
    endcase
    if ($urandom_range(9) != 0) begin
      push_text(q, $sformatf("%03d%02d.%s",
                             $urandom_range($urandom_range(9) ? 180 : 999),
                             $urandom_range($urandom_range(9) ? 59 : 99),
                             rnd_digits($urandom_range(8))));
    end
    case ($urandom_range(3))
      0: push_text(q, ",E,");
      1: push_text(q, ",W,");
      2: push_text(q, ",,");
      default: push_text(q, ",WEST,");
    endcase
    push_text(q, $sformatf("%0d,%0d", $urandom_range($urandom_range(9) ? 8 : 300),
                           $urandom_range($urandom_range(9) ? 20 : 300)));
    push_text(q, ",0.9,545.4,M,46.9,M,,");
    // stray byte somewhere inside the sentence
    if ($urandom_range(99) < 10) q[$urandom_range(1, q.size() - 1)] = $urandom_range(1, 255);
    r = $urandom_range(99);
    ck = (r < 42) ? CK_GOOD : (r < 82) ? CK_LOWER : (r < 89) ? CK_BAD :
         (r < 94) ? CK_NONE : CK_PAD;
    close_line(q, ck);
    if ($urandom_range(99) < 4) begin
      q.push_back($urandom_range(1) ? "F" : "x");
      q.push_back(8'hff);
    end
    if ($urandom_range(99) < 4) q[$urandom_range(q.size() - 1)] = 8'h00;
  endtask

  task automatic random_lines(input int bytes_target);
    int  stop_at;
    u8_t q[$];
    stop_at = n_bytes + bytes_target;
    while (n_bytes < stop_at) begin
      q.delete();
      random_line(q);
      send_line(q, NO_KNOWN);
    end
  endtask

  row_t rows[] = '{
    '{"$GPGGA,123519.25,4807.03812,N,01131.00000,E,1,08,0.9,545.4,M,46.9,M,,",
      CK_GOOD, NO_KNOWN},
    '{"$GNGGA,235959.9,9000.00000,S,18000.00000,W,2,12,,,,,,", CK_GOOD, NO_KNOWN},
    '{"$GPGGA,000000,0000.0,N,00000.0,E,0,00,,,,,", CK_GOOD, ST_NO_FIX},
    '{"$GPRMC,123519,A,4807.038,N", CK_GOOD, ST_NOT_GGA},
    '{"$GPGGA,1,2,N,3,E,1,8", CK_BAD, ST_BAD_SUM},
    '{"$GPGGA,1,2,N,3,E,1,8", CK_NONE, ST_BAD_SUM},
    '{"$GPG", CK_GOOD, ST_NOT_GGA},
    '{"GPGGA,1,2,N,3,E,1,8", CK_GOOD, ST_NOT_GGA},
    '{"$GPGGA,120000,4860.5,N,18000.00001,E,1,4", CK_GOOD, NO_KNOWN},
    '{"$GPGGA,999999999.12345,9959.99999999,N,-123,W,255,255", CK_LOWER, NO_KNOWN},
    '{"$GNGGA,1,1,N,1,E,1,3", CK_GOOD, ST_NO_FIX},
    '{"$GNGGA,,,,,,256,9", CK_GOOD, ST_NO_FIX},
    '{"$GNGGA,2.5,3500.999999,SOUTH,17959.99999,WEST,9,4", CK_LOWER, NO_KNOWN},
    '{"$GPGGA,1,1,N,1,E,1,9^,junk", CK_GOOD, ST_BAD_SUM},
    '{"$GPGGA,1~,1,N,1,E,1,9", CK_GOOD, NO_KNOWN},
    '{"$GPGGA,1,1,N,1,E,1,9", CK_PAD, ST_BAD_SUM},
    '{"", CK_GOOD, ST_NOT_GGA},
    '{"$GNGGA,12..5,12a4,N, 1,E,1,4", CK_GOOD, NO_KNOWN}
  };

  initial begin
    u8_t q[$];
    int  phase_idle[4], phase_stall[4];
    phase_idle  = '{0, 85, 0, 35};
    phase_stall = '{0, 0, 85, 35};
    min_sats = 4;
    clear_sentence();
    in_idle_pct = 0; out_stall_pct = 0; hold_out = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      q.delete();
      push_text(q, rows[i].body);
      // caret stands for a zero byte, tilde for 0xff
      foreach (q[j]) begin
        if (q[j] == "^") q[j] = 8'h00;
        else if (q[j] == "~") q[j] = 8'hff;
      end
      close_line(q, rows[i].ck);
      send_line(q, rows[i].known);
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      set_min_sats(p == 0 ? 0 : p == 1 ? 255 : p == 2 ? 1 : $urandom_range(2, 12));
      in_idle_pct = phase_idle[p];
      out_stall_pct = phase_stall[p];
      random_lines(RandBytes / 5);
      drain();
    end

    // receiver holds off while lines keep coming, so the block backs up
    set_min_sats(4);
    in_idle_pct = 0; out_stall_pct = 0;
    fork
      begin
        hold_out = 1;
        repeat (600) @(posedge clk_i);
        hold_out = 0;
      end
    join_none
    // short lines, far more of them than the block can hold
    repeat (40) begin
      q.delete();
      close_line(q, CK_GOOD);
      send_line(q, ST_NOT_GGA);
    end
    random_lines(RandBytes / 5);
    drain();

    in_idle_pct = 20; out_stall_pct = 20;
    while (n_lines < MinLines) random_lines(60);
    drain();

    $display("sent %0d bytes in %0d lines; %0d results checked, %0d accepted fixes",
             n_bytes, n_lines, n_checked, n_accepted);
    $display("covered idle and stall phases, a long output hold and satellite limits 0 to 255");
    if (errors == 0) begin
      $display("** nmea_gga_sentence_parser_unit: PASSED **");
    end else begin
      $display("** nmea_gga_sentence_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

[nmea_gga_sentence_parser_unit.f]
+incdir+sv
sv/ngga_pkg.sv
sv/ngga_front.sv
sv/ngga_queue.sv
sv/ngga_coord.sv
sv/ngga_back.sv
sv/nmea_gga_sentence_parser_unit.sv
tb/nmea_gga_sentence_parser_unit_tb.sv
